@@ src/sha256_pkg.sv @@
// SHA-256 package: beat types, round constants, initial hash values and round functions.
// Used by the byte stream hasher top level.
`timescale 1ns / 1ps
package sha256_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    unique case (i)
      3'd0: return 32'h6a09e667;
      3'd1: return 32'hbb67ae85;
      3'd2: return 32'h3c6ef372;
      3'd3: return 32'ha54ff53a;
      3'd4: return 32'h510e527f;
      3'd5: return 32'h9b05688c;
      3'd6: return 32'h1f83d9ab;
      default: return 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

@@ src/sha256_byte_stream_hasher.sv @@
// SHA-256 byte stream hasher: 64-entry byte memory, schedule and round logic; uses sha256_pkg.
// A byte beat is written to the byte memory; a 64th byte stalls input while the block loads,
// the rounds run and the result is folded into the chaining words. A finishing beat pads the
// rest of the block (or a whole second or fresh block), hashes each final block the same way,
// then sends 8 digest beats. One item at a time, input stalled until the digest is out.
// Reset clears fill count, bit count and control, loads init_h; the byte memory is undefined.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher
  import sha256_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StLoad = 3'd2;
  localparam logic [2:0] StRnd  = 3'd3;
  localparam logic [2:0] StFold = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [63:0] total_q, total_d;
  logic        fin_q, fin_d;      // block belongs to a finish
  logic        last_q, last_d;    // this finish block carries the length
  logic [6:0]  cnt_q, cnt_d;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [2:0]  oidx_q;
  logic        pend_fin_q;        // finishing beat that landed on a full block

  // byte memory, one port each for write and registered read
  logic [7:0] mem [64];
  logic       we;
  logic [5:0] waddr, raddr;
  logic [7:0] wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  in_beat_t ib;
  logic     in_acc;
  assign ib         = in_data_i;
  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;

  // padding byte for position cnt during a finish; length bytes sit at 56..63
  logic [7:0] pad_byte;
  always_comb begin
    if (last_q && cnt_q[5:0] >= LenPos) begin
      pad_byte = total_q[{~cnt_q[2:0], 3'd0} +: 8];
    end else if (cnt_q[5:0] == fill_q && !fin_q) begin
      pad_byte = PadByte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  // round datapath
  logic [31:0] wt, t1, t2, wnew;
  always_comb begin
    wt   = w_q[0];
    wnew = w_q[0] + sig0(w_q[1]) + w_q[9] + sig1(w_q[14]);
    t1   = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
           + round_k(cnt_q[5:0]) + wt;
    t2   = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // control
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    bits_d  = bits_q;
    total_d = total_q;
    fin_d   = fin_q;
    last_d  = last_q;
    cnt_d   = cnt_q;
    we      = 1'b0;
    waddr   = fill_q;
    wdata   = ib.msg_byte;
    raddr   = cnt_q[5:0];
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          fin_d  = 1'b0;
          last_d = 1'b0;
          cnt_d  = 7'd0;
          if (ib.byte_present) begin
            we     = 1'b1;
            fill_d = fill_q + 6'd1;
          end
          if (ib.byte_present && fill_q == 6'd63) begin
            // full block first; a finish pads a fresh block afterwards
            total_d = bits_q + 64'd512;
            state_d = StLoad;
          end else if (ib.end_of_message) begin
            total_d = bits_q + {55'd0, fill_d, 3'd0};
            cnt_d   = {1'b0, fill_d};
            last_d  = (fill_d < LenPos);
            state_d = StPad;
          end
        end
      end
      StPad: begin
        we    = 1'b1;
        waddr = cnt_q[5:0];
        wdata = pad_byte;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[5:0] == 6'd63) begin
          fin_d   = 1'b1;
          cnt_d   = 7'd0;
          state_d = StLoad;
        end
      end
      StLoad: begin
        // read bytes 0..63, each shifted into w in the next cycle
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd64) begin
          cnt_d   = 7'd0;
          state_d = StRnd;
        end
      end
      StRnd: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          state_d = StFold;
        end
      end
      StFold: begin
        cnt_d = 7'd0;
        if (!fin_q) begin
          bits_d  = bits_q + 64'd512;
          fill_d  = 6'd0;
          state_d = StIdle;
          if (pend_fin_q) begin
            // a finishing beat completed this block: pad a fresh one
            last_d  = 1'b1;
            state_d = StPad;
          end
        end else if (last_q) begin
          state_d = StOut;
        end else begin
          // length goes in a second block
          last_d  = 1'b1;
          state_d = StPad;
        end
      end
      StOut: begin
        if (!out_stall_i && oidx_q == 3'd7) begin
          state_d = StIdle;
          fill_d  = 6'd0;
          bits_d  = 64'd0;
          fin_d   = 1'b0;
          last_d  = 1'b0;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // remember a finish that arrived with the 64th byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_fin_q <= 1'b0;
    end else if (state_q == StIdle && in_acc) begin
      pend_fin_q <= ib.end_of_message && ib.byte_present && fill_q == 6'd63;
    end else if (state_q == StFold && !fin_q) begin
      pend_fin_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= 6'd0;
      bits_q  <= 64'd0;
      total_q <= 64'd0;
      fin_q   <= 1'b0;
      last_q  <= 1'b0;
      cnt_q   <= 7'd0;
      oidx_q  <= 3'd0;
      for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
      total_q <= total_d;
      fin_q   <= fin_d;
      last_q  <= last_d;
      cnt_q   <= cnt_d;
      if (state_q == StFold) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (state_q == StOut && !out_stall_i) begin
        oidx_q <= oidx_q + 3'd1;
        if (oidx_q == 3'd7) begin
          for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
        end
      end
    end
  end

  // schedule window and working variables
  always_ff @(posedge clk_i) begin
    if (state_q == StLoad && cnt_q != 7'd0) begin
      // bytes enter at the bottom; after 64 shifts word 0 sits in w_q[0]
      for (int i = 0; i < 15; i++) w_q[i] <= {w_q[i][23:0], w_q[i + 1][31:24]};
      w_q[15] <= {w_q[15][23:0], rdata_q};
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end
    if (state_q == StRnd) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
      w_q[15] <= wnew;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign out_valid_o            = (state_q == StOut);
  assign out_data_o.digest_word = h_q[oidx_q];
  assign out_data_o.word_index  = oidx_q;
  assign out_data_o.last_word   = (oidx_q == 3'd7);

endmodule
